/* rtl/sha256_hash_engine_top_assert.svh */
// assertion macros for the hash engine
`ifndef SHA256_HASH_ENGINE_TOP_ASSERT_SVH
`define SHA256_HASH_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/sha_pkg.sv */
`timescale 1ns / 1ps
package sha_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned SchedDepth = 16;
  localparam int unsigned SchedAw = 4;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [60:0] LenMax = {61{1'b1}};

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROUND, ST_ADD, ST_PAD, ST_OUT
  } state_e;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       last_item;
  } in_item_t;

  typedef struct packed {
    word_t      hash_word;
    logic [2:0] word_index;
    logic       last_word;
  } out_item_t;

  localparam word_t Iv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t v, int unsigned n);
    return (v >> n) | (v << (WordW - n));
  endfunction
endpackage

/* rtl/sha_stream_if.sv */
`timescale 1ns / 1ps
interface sha_in_if;
  logic              valid;
  logic              ready;
  sha_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sha_out_if;
  logic               valid;
  logic               ready;
  sha_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/sha_ram.sv */
`timescale 1ns / 1ps
module sha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* rtl/sha256_hash_engine_top.sv */
// one byte item per cycle while a block fills; a full block stalls input while
// its 64 rounds run and the result folds into the hash state, one round per cycle
// limited by the single schedule ram read per round
// last item: padding bytes one per cycle, one or two compressions, then 8 words
// asynchronous active-low reset returns hash state to the initial values
`timescale 1ns / 1ps
`include "sha256_hash_engine_top_assert.svh"
module sha256_hash_engine_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  sha_in_if.sink     in_if,
  sha_out_if.source  out_if
);
  import sha_pkg::*;

  state_e      state_q, state_d;
  word_t       h_q [8];
  word_t       h_d [8];
  word_t       v_q [8];
  word_t       v_d [8];
  word_t       win_q [16];
  word_t       win_d [16];
  logic [5:0]  pos_q, pos_d;
  logic [60:0] len_q, len_d;
  logic [5:0]  rnd_q, rnd_d;
  logic        fin_q, fin_d;
  logic [3:0]  pad_q, pad_d;
  logic [63:0] bits_q, bits_d;
  logic [2:0]  oidx_q, oidx_d;
  logic        in_fire;
  logic        out_fire;
  logic        last_round;
  logic        last_out;
  logic        push;
  logic [7:0]  push_byte;
  word_t       wnew, w2, w15, w7, w16, wcur, t1, t2;
  logic        sch_we;
  logic [SchedAw-1:0] sch_addr;
  logic [SchedAw-1:0] sch_raddr;
  word_t       sch_wdata, sch_rdata;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_fire = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign last_round = (state_q == ST_ROUND) && (rnd_q == 6'd63);
  assign last_out = out_fire && (oidx_q == 3'd7);

  // ram supplies each round's message word or w[t-16] tap from a registered read
  // window registers feed the expansion taps
  assign sch_we = push || (state_q == ST_ROUND);
  assign sch_addr = (state_q == ST_ROUND) ? rnd_q[3:0] : pos_q[5:2];
  assign sch_raddr = (state_q == ST_ROUND) ? 4'(rnd_q + 6'd1) : '0;
  assign sch_wdata = (state_q == ST_ROUND) ? wcur : win_d[pos_q[5:2]];

  sha_ram #(.Width(WordW), .Depth(SchedDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (sch_we),
    .waddr_i (sch_addr),
    .wdata_i (sch_wdata),
    .raddr_i (sch_raddr),
    .rdata_o (sch_rdata)
  );

  always_comb begin
    w2   = win_q[4'(rnd_q - 6'd2)];
    w15  = win_q[4'(rnd_q - 6'd15)];
    w7   = win_q[4'(rnd_q - 6'd7)];
    w16  = sch_rdata;
    wnew = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + w7
         + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + w16;
    wcur = (rnd_q >= 6'd16) ? wnew : w16;
    t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[rnd_q] + wcur;
    t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_comb begin
    state_d = state_q;
    h_d = h_q;
    v_d = v_q;
    win_d = win_q;
    pos_d = pos_q;
    len_d = len_q;
    rnd_d = rnd_q;
    fin_d = fin_q;
    pad_d = pad_q;
    bits_d = bits_q;
    oidx_d = oidx_q;
    push = 1'b0;
    push_byte = '0;
    out_if.valid = (state_q == ST_OUT);
    out_if.data.hash_word = h_q[oidx_q];
    out_if.data.word_index = oidx_q;
    out_if.data.last_word = (oidx_q == 3'd7);
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_if.data.byte_valid) begin
            push = 1'b1;
            push_byte = in_if.data.msg_byte;
            if (len_q != LenMax) begin
              len_d = len_q + 61'd1;
            end
          end
          if (in_if.data.last_item) begin
            fin_d = 1'b1;
            pad_d = '0;
            bits_d = {((len_d == LenMax || len_q == LenMax) ? LenMax : len_d), 3'b000};
          end
        end
      end
      ST_PAD: begin
        push = 1'b1;
        if (pad_q == 4'd0) begin
          push_byte = PadByte;
          pad_d = 4'd1;
        end else if (pad_q == 4'd1 && pos_q != 6'd56) begin
          push_byte = 8'h00;
        end else begin
          push_byte = bits_q[63:56];
          bits_d = {bits_q[55:0], 8'h00};
          pad_d = pad_q + 4'd1;
        end
      end
      ST_ROUND: begin
        win_d[rnd_q[3:0]] = wcur;
        v_d[7] = v_q[6]; v_d[6] = v_q[5]; v_d[5] = v_q[4]; v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2]; v_d[2] = v_q[1]; v_d[1] = v_q[0]; v_d[0] = t1 + t2;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (pad_q == 4'd9) begin
          state_d = ST_OUT;
          oidx_d = '0;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_if.ready) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            state_d = ST_IDLE;
            h_d = Iv;
            v_d = '{default: '0};
            len_d = '0;
            pos_d = '0;
            fin_d = 1'b0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (push) begin
      if (pos_q[1:0] == 2'd0) begin
        win_d[pos_q[5:2]] = {24'd0, push_byte};
      end else begin
        win_d[pos_q[5:2]] = {win_q[pos_q[5:2]][23:0], push_byte};
      end
      pos_d = pos_q + 6'd1;
      if (pos_q == 6'd63) begin
        state_d = ST_ROUND;
        rnd_d = '0;
        v_d = h_q;
      end else if (state_q == ST_IDLE && in_fire && in_if.data.last_item) begin
        state_d = ST_PAD;
      end else if (state_q == ST_PAD && pad_q == 4'd9) begin
        state_d = ST_OUT;
      end
    end else if (state_q == ST_IDLE && in_fire && in_if.data.last_item) begin
      state_d = ST_PAD;
    end
    if (state_q == ST_PAD && push && pad_q == 4'd8) begin
      pad_d = 4'd9;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      h_q <= Iv;
      v_q <= '{default: '0};
      pos_q <= '0;
      len_q <= '0;
      rnd_q <= '0;
      fin_q <= 1'b0;
      pad_q <= '0;
      oidx_q <= '0;
    end else begin
      state_q <= state_d;
      h_q <= h_d;
      v_q <= v_d;
      pos_q <= pos_d;
      len_q <= len_d;
      rnd_q <= rnd_d;
      fin_q <= fin_d;
      pad_q <= pad_d;
      oidx_q <= oidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    bits_q <= bits_d;
  end

  `SHA_ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, state_q != ST_IDLE, !in_fire)
  `SHA_ASSERT_NEXT(a_round_to_add, clk_i, rst_ni, last_round, state_q == ST_ADD)
  `SHA_ASSERT_NEXT(a_out_done, clk_i, rst_ni, last_out, state_q == ST_IDLE && pos_q == 6'd0)
  `SHA_ASSERT_IMPL(a_out_only_final, clk_i, rst_ni, out_if.valid, fin_q && pos_q == 6'd0)
endmodule
